/* design/fes_pkg.sv */
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types and constants of the fade envelope sequencer: payload structs,
// action, phase and register codes, datapath widths and the sequencer states.
// ----------------------------------------------------------------------------
package fes_pkg;

    localparam int TIME_BITS  = 16;
    localparam int ELAPSED_W  = TIME_BITS + 1;
    localparam int LEVEL_W    = 16;
    localparam int CFG_W      = 16;
    localparam int PROD_W     = 2 * LEVEL_W;
    localparam int DIV_CNT_W  = $clog2(LEVEL_W);
    localparam int CFG_IDX_W  = 3;

    localparam logic [LEVEL_W-1:0]   FULL_LEVEL  = {LEVEL_W{1'b1}};
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // action codes
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SHOW = 2'd1;
    localparam logic [1:0] ACT_HIDE = 2'd2;

    // phase codes
    localparam logic [2:0] PH_PREDELAY = 3'd0;
    localparam logic [2:0] PH_FADE_IN  = 3'd1;
    localparam logic [2:0] PH_HOLD     = 3'd2;
    localparam logic [2:0] PH_PRE_OUT  = 3'd3;
    localparam logic [2:0] PH_FADE_OUT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_IN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_OUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT  = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] elapsed_ticks;
    } in_item_t;

    typedef struct packed {
        logic [15:0] opacity;
        logic        shown;
        logic [2:0]  phase;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK_ADD,
        ST_TICK_CMP,
        ST_RAMP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

endpackage

/* design/fes_divider.sv */
// ----------------------------------------------------------------------------
// fes_divider
// Serial restoring divider: one compare and subtract per cycle, one quotient
// bit per step. Expects dividend[31:16] < divisor so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
module fes_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fes_pkg::PROD_W-1:0]   dividend,
    input  logic [fes_pkg::LEVEL_W-1:0]  divisor,
    output logic                         done,
    output logic [fes_pkg::LEVEL_W-1:0]  quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [fes_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [fes_pkg::LEVEL_W-1:0]     rem_reg, rem_next;
    logic [fes_pkg::LEVEL_W-1:0]     quo_reg, quo_next;
    logic [fes_pkg::LEVEL_W-1:0]     dsr_reg, dsr_next;
    logic [fes_pkg::LEVEL_W:0]       shifted;
    logic [fes_pkg::LEVEL_W:0]       diff;
    logic                            ge;

    assign shifted = {rem_reg, quo_reg[fes_pkg::LEVEL_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = {fes_pkg::DIV_CNT_W{1'b1}};
            rem_next  = dividend[fes_pkg::PROD_W-1:fes_pkg::LEVEL_W];
            quo_next  = dividend[fes_pkg::LEVEL_W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[fes_pkg::LEVEL_W-1:0] : shifted[fes_pkg::LEVEL_W-1:0];
            quo_next = {quo_reg[fes_pkg::LEVEL_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/fade_envelope_sequencer_core.sv */
// ----------------------------------------------------------------------------
// fade_envelope_sequencer_core
// Five-phase opacity envelope (delay, fade in, hold, delay, fade out) driven
// by tick, show and hide items, with ramp progress from a serial divider.
// ----------------------------------------------------------------------------
// one item is in flight at a time: a new item is accepted only after the previous
//   result has been registered for output; ticks that land inside a ramp and ramp
//   reversals go through the 16-step serial divider, and a full output slot stalls
//   the finish state until the receiver takes the last result
// reset: asynchronous, clears configuration registers, phase, elapsed time, opacity, shown
module fade_envelope_sequencer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  fes_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output fes_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fes_pkg::CFG_W-1:0]       cfg_data
);

    fes_pkg::state_t                 state_reg, state_next;

    logic [fes_pkg::CFG_W-1:0]       delay_in_reg, fade_in_reg, hold_reg;
    logic [fes_pkg::CFG_W-1:0]       delay_out_reg, fade_out_reg;

    logic [2:0]                      phase_reg, phase_next;
    logic [fes_pkg::ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [fes_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic                            shown_reg, shown_next;

    fes_pkg::in_item_t               item_reg, item_next;
    logic [fes_pkg::LEVEL_W-1:0]     frac_reg, frac_next;
    logic                            rev_reg, rev_next;
    logic [fes_pkg::PROD_W-1:0]      dividend_reg, dividend_next;
    logic [fes_pkg::LEVEL_W-1:0]     divisor_reg, divisor_next;

    logic                            out_valid_reg, out_valid_next;
    fes_pkg::out_item_t              out_reg, out_next;

    logic [fes_pkg::LEVEL_W-1:0]     lim;
    logic                            expired;
    logic [fes_pkg::ELAPSED_W:0]     sum;
    logic                            slot_free;
    logic                            div_start;
    logic                            div_done;
    logic [fes_pkg::LEVEL_W-1:0]     div_q;

    // limit of the current phase; unused codes fall back to hold
    always_comb
    begin
        case (phase_reg)
            fes_pkg::PH_PREDELAY: lim = delay_in_reg;
            fes_pkg::PH_FADE_IN:  lim = fade_in_reg;
            fes_pkg::PH_PRE_OUT:  lim = delay_out_reg;
            fes_pkg::PH_FADE_OUT: lim = fade_out_reg;
            default:              lim = hold_reg;
        endcase
    end

    assign expired   = elapsed_reg >= {1'b0, lim};
    assign sum       = {1'b0, elapsed_reg} + {2'b00, item_reg.elapsed_ticks};
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == fes_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_in_reg  <= '0;
            fade_in_reg   <= '0;
            hold_reg      <= '0;
            delay_out_reg <= '0;
            fade_out_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fes_pkg::REG_DELAY_IN:  delay_in_reg  <= cfg_data;
                fes_pkg::REG_FADE_IN:   fade_in_reg   <= cfg_data;
                fes_pkg::REG_HOLD:      hold_reg      <= cfg_data;
                fes_pkg::REG_DELAY_OUT: delay_out_reg <= cfg_data;
                fes_pkg::REG_FADE_OUT:  fade_out_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fes_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = fes_pkg::ST_DECODE;
            end
            fes_pkg::ST_DECODE:
            begin
                state_next = fes_pkg::ST_FINISH;
                case (item_reg.action)
                    fes_pkg::ACT_TICK:
                    begin
                        if (shown_reg)
                            state_next = fes_pkg::ST_TICK_ADD;
                    end
                    fes_pkg::ACT_SHOW:
                    begin
                        if (shown_reg && phase_reg == fes_pkg::PH_FADE_OUT)
                            state_next = fes_pkg::ST_MUL;
                    end
                    fes_pkg::ACT_HIDE:
                    begin
                        if (shown_reg && phase_reg == fes_pkg::PH_FADE_IN)
                            state_next = fes_pkg::ST_MUL;
                    end
                    default: ;
                endcase
            end
            fes_pkg::ST_TICK_ADD: state_next = fes_pkg::ST_TICK_CMP;
            fes_pkg::ST_TICK_CMP: state_next = fes_pkg::ST_RAMP;
            fes_pkg::ST_RAMP:
            begin
                if ((phase_reg == fes_pkg::PH_FADE_IN || phase_reg == fes_pkg::PH_FADE_OUT)
                    && !expired)
                    state_next = fes_pkg::ST_DIV_GO;
                else
                    state_next = fes_pkg::ST_FINISH;
            end
            fes_pkg::ST_MUL:    state_next = fes_pkg::ST_DIV_GO;
            fes_pkg::ST_DIV_GO: state_next = fes_pkg::ST_DIV_WAIT;
            fes_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = fes_pkg::ST_FINISH;
            end
            fes_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = fes_pkg::ST_IDLE;
            end
            default: state_next = fes_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        level_next     = level_reg;
        shown_next     = shown_reg;
        item_next      = item_reg;
        frac_next      = frac_reg;
        rev_next       = rev_reg;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        case (state_reg)
            fes_pkg::ST_IDLE:
            begin
                if (in_valid)
                    item_next = in_data;
            end
            fes_pkg::ST_DECODE:
            begin
                case (item_reg.action)
                    fes_pkg::ACT_SHOW:
                    begin
                        shown_next = 1'b1;
                        if (!shown_reg)
                        begin
                            level_next   = '0;
                            phase_next   = fes_pkg::PH_PREDELAY;
                            elapsed_next = '0;
                        end
                        else if (phase_reg == fes_pkg::PH_FADE_OUT)
                        begin
                            phase_next = fes_pkg::PH_FADE_IN;
                            frac_next  = level_reg;
                        end
                        else if (phase_reg != fes_pkg::PH_PREDELAY
                                 && phase_reg != fes_pkg::PH_FADE_IN)
                        begin
                            phase_next   = fes_pkg::PH_HOLD;
                            elapsed_next = '0;
                        end
                    end
                    fes_pkg::ACT_HIDE:
                    begin
                        if (shown_reg && phase_reg != fes_pkg::PH_PRE_OUT
                            && phase_reg != fes_pkg::PH_FADE_OUT)
                        begin
                            if (phase_reg == fes_pkg::PH_PREDELAY)
                            begin
                                elapsed_next = '0;
                                shown_next   = 1'b0;
                            end
                            else if (phase_reg == fes_pkg::PH_FADE_IN)
                            begin
                                phase_next = fes_pkg::PH_FADE_OUT;
                                frac_next  = fes_pkg::FULL_LEVEL - level_reg;
                            end
                            else
                            begin
                                phase_next   = fes_pkg::PH_PRE_OUT;
                                elapsed_next = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            fes_pkg::ST_TICK_ADD:
            begin
                if (sum[fes_pkg::ELAPSED_W])
                    elapsed_next = fes_pkg::ELAPSED_MAX;
                else
                    elapsed_next = sum[fes_pkg::ELAPSED_W-1:0];
            end
            fes_pkg::ST_TICK_CMP:
            begin
                // overrun carries into the next phase once
                if (expired)
                begin
                    elapsed_next = elapsed_reg - {1'b0, lim};
                    if (phase_reg >= fes_pkg::PH_FADE_OUT)
                    begin
                        phase_next = fes_pkg::PH_PREDELAY;
                        level_next = '0;
                        shown_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = phase_reg + 3'd1;
                        if (phase_reg == fes_pkg::PH_FADE_IN)
                            level_next = fes_pkg::FULL_LEVEL;
                    end
                end
            end
            fes_pkg::ST_RAMP:
            begin
                // progress = elapsed * 65535 / limit, full once the limit is reached
                if (phase_reg == fes_pkg::PH_FADE_IN || phase_reg == fes_pkg::PH_FADE_OUT)
                begin
                    if (expired)
                        level_next = (phase_reg == fes_pkg::PH_FADE_IN) ?
                                     fes_pkg::FULL_LEVEL : '0;
                    else
                    begin
                        dividend_next = {elapsed_reg[fes_pkg::LEVEL_W-1:0],
                                         {fes_pkg::LEVEL_W{1'b0}}}
                                      - {{fes_pkg::LEVEL_W{1'b0}},
                                         elapsed_reg[fes_pkg::LEVEL_W-1:0]};
                        divisor_next  = lim;
                        rev_next      = 1'b0;
                    end
                end
            end
            fes_pkg::ST_MUL:
            begin
                // reversal: elapsed = frac * limit / 65535
                dividend_next = {{fes_pkg::LEVEL_W{1'b0}}, frac_reg}
                              * {{fes_pkg::LEVEL_W{1'b0}}, lim};
                divisor_next  = fes_pkg::FULL_LEVEL;
                rev_next      = 1'b1;
            end
            fes_pkg::ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            fes_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (rev_reg)
                        elapsed_next = {1'b0, div_q};
                    else if (phase_reg == fes_pkg::PH_FADE_IN)
                        level_next = div_q;
                    else
                        level_next = fes_pkg::FULL_LEVEL - div_q;
                end
            end
            fes_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.opacity = level_reg;
                    out_next.shown   = shown_reg;
                    out_next.phase   = phase_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fes_pkg::ST_IDLE;
            phase_reg     <= fes_pkg::PH_PREDELAY;
            elapsed_reg   <= '0;
            level_reg     <= '0;
            shown_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            level_reg     <= level_next;
            shown_reg     <= shown_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        frac_reg     <= frac_next;
        rev_reg      <= rev_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        out_reg      <= out_next;
    end

    fes_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // hidden always means parked in the predelay
    a_hidden_predelay: assert property (@(posedge clk) disable iff (!rst_n)
        !shown_reg |-> phase_reg == fes_pkg::PH_PREDELAY)
        else $error("hidden outside predelay");

    // hold and the delay before fade-out sit at full opacity
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fes_pkg::PH_HOLD || phase_reg == fes_pkg::PH_PRE_OUT)
        |-> level_reg == fes_pkg::FULL_LEVEL)
        else $error("opacity not full in hold");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= fes_pkg::PH_FADE_OUT)
        else $error("phase out of range");

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second item while busy");

endmodule

/* tb/tb_fade_envelope_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_fade_envelope_sequencer_core
// Self-checking bench for the fade envelope sequencer. Tick, show and hide
// items go in through a bursty driver, and results come back through a
// receiver that stalls on its own pattern. Each result is checked field by
// field against a cycle-free envelope predictor kept inside the bench.
// Phase lengths are reprogrammed between runs, from all zero to all maximum.
// ----------------------------------------------------------------------------
module tb_fade_envelope_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [fes_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [fes_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int RANDOM_SETTINGS = 10;
    localparam int ITEMS_PER_SETTING = 183;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    fes_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    fes_pkg::out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fes_pkg::CFG_W-1:0] cfg_data = '0;

    fade_envelope_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // envelope state as the predictor sees it
    logic [fes_pkg::CFG_W-1:0]     phase_lengths [0:4] = '{default: '0};
    logic [2:0]                    env_phase = fes_pkg::PH_PREDELAY;
    logic [fes_pkg::ELAPSED_W-1:0] env_elapsed = '0;
    logic [fes_pkg::LEVEL_W-1:0]   env_level = '0;
    logic                          env_shown = 1'b0;

    fes_pkg::in_item_t  pending_items [$];
    fes_pkg::out_item_t expected_envelopes [$];

    bit in_fire = 1'b0;
    bit cfg_fire = 1'b0;
    int pushed_count = 0;
    int accepted_count = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int settings_applied = 0;
    int action_count [0:3] = '{default: 0};
    logic [4:0] phases_reported = '0;

    function automatic logic [fes_pkg::CFG_W-1:0] length_of(logic [2:0] ph);
        case (ph)
            fes_pkg::PH_PREDELAY: return phase_lengths[fes_pkg::REG_DELAY_IN];
            fes_pkg::PH_FADE_IN:  return phase_lengths[fes_pkg::REG_FADE_IN];
            fes_pkg::PH_PRE_OUT:  return phase_lengths[fes_pkg::REG_DELAY_OUT];
            fes_pkg::PH_FADE_OUT: return phase_lengths[fes_pkg::REG_FADE_OUT];
            default:              return phase_lengths[fes_pkg::REG_HOLD];
        endcase
    endfunction

    function automatic logic [fes_pkg::LEVEL_W-1:0] ramp_fraction();
        logic [63:0] num;
        logic [fes_pkg::CFG_W-1:0] len;
        len = length_of(env_phase);
        if (env_elapsed >= len)
            return fes_pkg::FULL_LEVEL;
        num = 64'(env_elapsed) * 64'(fes_pkg::FULL_LEVEL);
        num = num / 64'(len);
        return num[fes_pkg::LEVEL_W-1:0];
    endfunction

    // elapsed time that puts a ramp at the given fraction of full scale
    function automatic logic [fes_pkg::ELAPSED_W-1:0] elapsed_at(
            logic [fes_pkg::LEVEL_W-1:0] frac, logic [2:0] ph);
        logic [63:0] num;
        num = 64'(frac) * 64'(length_of(ph));
        num = num / 64'(fes_pkg::FULL_LEVEL);
        return num[fes_pkg::ELAPSED_W-1:0];
    endfunction

    function automatic fes_pkg::out_item_t step_envelope(fes_pkg::in_item_t it);
        logic [fes_pkg::ELAPSED_W+1:0] sum;
        logic [fes_pkg::CFG_W-1:0] len;
        fes_pkg::out_item_t res;
        case (it.action)
            fes_pkg::ACT_TICK:
                if (env_shown)
                begin
                    sum = env_elapsed + it.elapsed_ticks;
                    if (sum > fes_pkg::ELAPSED_MAX)
                        sum = fes_pkg::ELAPSED_MAX;
                    len = length_of(env_phase);
                    if (sum >= len)
                    begin
                        // overrun carries once into the next phase
                        sum = sum - len;
                        env_phase = (env_phase >= fes_pkg::PH_FADE_OUT) ?
                                    fes_pkg::PH_PREDELAY : env_phase + 3'd1;
                        if (env_phase == fes_pkg::PH_HOLD)
                            env_level = fes_pkg::FULL_LEVEL;
                        else if (env_phase == fes_pkg::PH_PREDELAY)
                        begin
                            env_level = '0;
                            env_shown = 1'b0;
                        end
                    end
                    env_elapsed = sum[fes_pkg::ELAPSED_W-1:0];
                    if (env_phase == fes_pkg::PH_FADE_IN)
                        env_level = ramp_fraction();
                    else if (env_phase == fes_pkg::PH_FADE_OUT)
                        env_level = fes_pkg::FULL_LEVEL - ramp_fraction();
                end
            fes_pkg::ACT_SHOW:
            begin
                if (!env_shown)
                begin
                    env_level = '0;
                    env_phase = fes_pkg::PH_PREDELAY;
                    env_elapsed = '0;
                end
                else if (env_phase == fes_pkg::PH_FADE_OUT)
                begin
                    env_phase = fes_pkg::PH_FADE_IN;
                    env_elapsed = elapsed_at(env_level, fes_pkg::PH_FADE_IN);
                end
                else if (env_phase != fes_pkg::PH_PREDELAY
                         && env_phase != fes_pkg::PH_FADE_IN)
                begin
                    env_phase = fes_pkg::PH_HOLD;
                    env_elapsed = '0;
                end
                env_shown = 1'b1;
            end
            fes_pkg::ACT_HIDE:
                if (env_shown && env_phase != fes_pkg::PH_PRE_OUT
                    && env_phase != fes_pkg::PH_FADE_OUT)
                begin
                    if (env_phase == fes_pkg::PH_PREDELAY)
                    begin
                        env_elapsed = '0;
                        env_shown = 1'b0;
                    end
                    else if (env_phase == fes_pkg::PH_FADE_IN)
                    begin
                        env_phase = fes_pkg::PH_FADE_OUT;
                        env_elapsed = elapsed_at(fes_pkg::FULL_LEVEL - env_level,
                                                 fes_pkg::PH_FADE_OUT);
                    end
                    else
                    begin
                        env_phase = fes_pkg::PH_PRE_OUT;
                        env_elapsed = '0;
                    end
                end
            default: ;
        endcase
        res.opacity = env_level;
        res.shown = env_shown;
        res.phase = env_phase;
        return res;
    endfunction

    // monitor: register writes, accepted items and returned results
    always @(posedge clk)
    begin : monitor
        fes_pkg::out_item_t want;
        in_fire = rst_n && in_valid && in_ready;
        cfg_fire = rst_n && cfg_valid && cfg_ready;
        if (cfg_fire && cfg_index <= fes_pkg::REG_FADE_OUT)
            phase_lengths[cfg_index] = cfg_data;
        if (in_fire)
        begin
            expected_envelopes.push_back(step_envelope(in_data));
            action_count[in_data.action]++;
            accepted_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (out_data.phase <= fes_pkg::PH_FADE_OUT)
                phases_reported[out_data.phase] = 1'b1;
            if (expected_envelopes.size() == 0)
            begin
                $error("result with nothing expected: opacity %0d shown %0d phase %0d",
                       out_data.opacity, out_data.shown, out_data.phase);
                mismatch_count++;
            end
            else
            begin
                want = expected_envelopes.pop_front();
                if (out_data.opacity !== want.opacity)
                begin
                    $error("opacity: expected %0d, actual %0d", want.opacity,
                           out_data.opacity);
                    mismatch_count++;
                end
                if (out_data.shown !== want.shown)
                begin
                    $error("shown: expected %0d, actual %0d", want.shown, out_data.shown);
                    mismatch_count++;
                end
                if (out_data.phase !== want.phase)
                begin
                    $error("phase: expected %0d, actual %0d", want.phase, out_data.phase);
                    mismatch_count++;
                end
            end
        end
    end

    // driver: bursts of items with random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : driver
        logic next_valid;
        fes_pkg::in_item_t next_data;
        next_valid = in_valid;
        next_data = in_data;
        if (rst_n && (!in_valid || in_fire))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                next_data = pending_items.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
        in_valid <= next_valid;
        in_data <= next_data;
    end

    // receiver: stall pattern changes mode every so often, plus one long hold
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_count = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    always @(negedge clk)
    begin : receiver
        logic rdy;
        rdy = 1'b0;
        rx_count++;
        if (!rst_n)
            rdy = 1'b0;
        else if (hold_left > 0)
            hold_left--;
        else if (!long_hold_done && results_checked >= LONG_HOLD_AFTER)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = (rx_count % 7) < 2;
                default: rdy = $urandom_range(0, 7) != 0;
            endcase
        end
        out_ready <= rdy;
    end

    task automatic push_item(logic [1:0] act, logic [15:0] ticks);
        fes_pkg::in_item_t it;
        it.action = act;
        it.elapsed_ticks = ticks;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    // wait for every item to be taken and answered, then let the block settle
    task automatic wait_drained();
        while (accepted_count != pushed_count || expected_envelopes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [fes_pkg::CFG_IDX_W-1:0] idx,
                             logic [fes_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_fire)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_lengths(logic [fes_pkg::CFG_W-1:0] d_in,
                                 logic [fes_pkg::CFG_W-1:0] f_in,
                                 logic [fes_pkg::CFG_W-1:0] hold,
                                 logic [fes_pkg::CFG_W-1:0] d_out,
                                 logic [fes_pkg::CFG_W-1:0] f_out);
        write_reg(fes_pkg::REG_DELAY_IN, d_in);
        write_reg(fes_pkg::REG_FADE_IN, f_in);
        write_reg(fes_pkg::REG_HOLD, hold);
        write_reg(fes_pkg::REG_DELAY_OUT, d_out);
        write_reg(fes_pkg::REG_FADE_OUT, f_out);
        settings_applied++;
    endtask

    function automatic logic [fes_pkg::CFG_W-1:0] pick_length();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 16'd1;
            3, 4: return 16'($urandom_range(2, 60));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] tick_amount(int scale);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, scale));
        endcase
    endfunction

    // mostly show-then-ticks sequences with random show/hide mixed in,
    // now and then a burst of arbitrary items
    task automatic queue_random_items(int n_items, int scale);
        int made;
        int r;
        logic [1:0] act;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_item(2'($urandom), tick_amount(scale));
                    made++;
                end
            end
            else
            begin
                push_item(fes_pkg::ACT_SHOW, 16'($urandom));
                made++;
                repeat ($urandom_range(4, 30))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        act = fes_pkg::ACT_TICK;
                    else if (r < 88)
                        act = fes_pkg::ACT_SHOW;
                    else if (r < 97)
                        act = fes_pkg::ACT_HIDE;
                    else
                        act = ACT_UNUSED;
                    push_item(act, tick_amount(scale));
                    made++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [fes_pkg::CFG_W-1:0] lens [0:4];
        int scale;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all lengths zero after reset: ignored items, then saturating ticks
        push_item(fes_pkg::ACT_TICK, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'hFFFF);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(ACT_UNUSED, 16'hFFFF);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'hFFFF);
        push_item(fes_pkg::ACT_TICK, 16'hFFFF);
        push_item(fes_pkg::ACT_TICK, 16'hFFFF);
        push_item(fes_pkg::ACT_TICK, 16'd1);
        wait_drained();

        // short phases: show and hide across the phases, both reversals
        apply_lengths(16'd3, 16'd10, 16'd5, 16'd4, 16'd12);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0001);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'd5);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'd20);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'd4);
        push_item(fes_pkg::ACT_TICK, 16'd3);
        push_item(fes_pkg::ACT_HIDE, 16'd0);
        push_item(fes_pkg::ACT_SHOW, 16'd0);
        push_item(fes_pkg::ACT_TICK, 16'hFFFF);
        wait_drained();

        for (int k = 0; k < RANDOM_SETTINGS; k++)
        begin
            for (int j = 0; j < 5; j++)
            begin
                if (k == 0)
                    lens[j] = '0;
                else if (k == 1)
                    lens[j] = '1;
                else if (k == 2)
                    lens[j] = (j % 2) ? '1 : '0;
                else
                    lens[j] = pick_length();
            end
            apply_lengths(lens[0], lens[1], lens[2], lens[3], lens[4]);
            scale = 0;
            for (int j = 0; j < 5; j++)
                if (lens[j] > scale)
                    scale = lens[j];
            scale = scale / 6 + 2;
            queue_random_items(ITEMS_PER_SETTING, scale);
            wait_drained();
        end

        $display("covered %0d items: %0d ticks, %0d show, %0d hide, %0d unused action",
                 accepted_count, action_count[fes_pkg::ACT_TICK],
                 action_count[fes_pkg::ACT_SHOW], action_count[fes_pkg::ACT_HIDE],
                 action_count[ACT_UNUSED]);
        $display("%0d results checked over %0d length settings, phases seen %b",
                 results_checked, settings_applied, phases_reported);
        if (mismatch_count == 0)
            $display("fade_envelope_sequencer_core verification clean");
        else
            $display("fade_envelope_sequencer_core verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("fade_envelope_sequencer_core verification failed");
        $finish;
    end

endmodule

/* files.f */
design/fes_pkg.sv
design/fes_divider.sv
design/fade_envelope_sequencer_core.sv
tb/tb_fade_envelope_sequencer_core.sv
